FILE: sv/lpfe_pkg.sv
package lpfe_pkg;

  // Register limits
  localparam int unsigned CfgWidth = 17;
  localparam logic [CfgWidth-1:0] MaxTotalCap   = 17'd65536;
  localparam logic [CfgWidth-1:0] MaxTotalReset = 17'd16384;

  // Header length word occupies four bytes
  localparam logic [17:0] HeaderBytes = 18'd4;

  // Kind of a result transaction
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_RESYNC  = 1'b1
  } kind_e;

  // One result transaction
  typedef struct packed {
    logic [7:0]  out_byte;
    kind_e       kind;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [15:0] payload_len;
  } res_t;

endpackage

FILE: sv/length_prefixed_frame_extractor.sv
// A result is registered in the output register, or in the skid register while the output register is stalled.
// Throughput: one byte per cycle; input stall is raised only while the skid
// register holds a result behind a stalled output register.
// Reset (rst_ni, async, active low) empties the window, leaves any frame,
// clears the output stage and sets max_total_len to 16384.
module length_prefixed_frame_extractor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpfe_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          kind_o,
  output logic                          first_of_frame_o,
  output logic                          last_of_frame_o,
  output logic [15:0]                   payload_len_o
);

  logic           take;
  logic           res_valid;
  lpfe_pkg::res_t res;
  logic           out_valid_q, skid_valid_q;
  lpfe_pkg::res_t out_q, skid_q;
  logic           out_pop;

  assign in_stall_o = skid_valid_q;
  assign take       = in_valid_i && !skid_valid_q;
  assign out_pop    = out_valid_q && !out_stall_i;

  lpfe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_q.out_byte;
  assign kind_o           = out_q.kind;
  assign first_of_frame_o = out_q.first_of_frame;
  assign last_of_frame_o  = out_q.last_of_frame;
  assign payload_len_o    = out_q.payload_len;

  // Skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stalled output");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid transaction lost while output stalled");

endmodule

FILE: sv/lpfe_core.sv
module lpfe_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpfe_pkg::CfgWidth-1:0]  cfg_wdata_i,
  input  logic                           take_i,
  input  logic [7:0]                     data_byte_i,
  output logic                           res_valid_o,
  output lpfe_pkg::res_t                 res_o
);

  logic [lpfe_pkg::CfgWidth-1:0] max_len_q;
  logic [31:0] win_q, win_d;
  logic [1:0]  fill_q, fill_d;
  logic        in_payload_q, in_payload_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [15:0] frame_len_q, frame_len_d;

  logic [31:0] win_ins;
  logic [lpfe_pkg::CfgWidth-1:0] cap;
  logic        hdr_ok;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lpfe_pkg::MaxTotalReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // Place the new byte above those already held
  always_comb begin
    win_ins = win_q;
    for (int i = 0; i < 4; i++) begin
      if (fill_q == 2'(i)) begin
        win_ins[8*i +: 8] = data_byte_i;
      end
    end
  end

  // Header test: 1 <= length <= cap - 4, cap clamped to 65536
  assign cap = (max_len_q > lpfe_pkg::MaxTotalCap) ? lpfe_pkg::MaxTotalCap : max_len_q;
  assign hdr_ok = (win_ins[31:16] == 16'd0) && (win_ins[15:0] != 16'd0) &&
                  (({2'b00, win_ins[15:0]} + lpfe_pkg::HeaderBytes) <= {1'b0, cap});

  // Next state and result
  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    in_payload_d = in_payload_q;
    bytes_left_d = bytes_left_q;
    frame_len_d  = frame_len_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (take_i) begin
      if (in_payload_q) begin
        // Pass payload byte with marks
        res_valid_o          = 1'b1;
        res_o.out_byte       = data_byte_i;
        res_o.kind           = lpfe_pkg::KIND_PAYLOAD;
        res_o.first_of_frame = (bytes_left_q == frame_len_q);
        res_o.last_of_frame  = (bytes_left_q <= 16'd1);
        res_o.payload_len    = frame_len_q;
        bytes_left_d = (bytes_left_q != 16'd0) ? bytes_left_q - 16'd1 : 16'd0;
        if (bytes_left_q <= 16'd1) begin
          in_payload_d = 1'b0;
        end
      end else if (fill_q != 2'd3) begin
        // Collect header byte
        win_d  = win_ins;
        fill_d = fill_q + 2'd1;
      end else if (hdr_ok) begin
        // Start a frame
        win_d        = '0;
        fill_d       = 2'd0;
        in_payload_d = 1'b1;
        frame_len_d  = win_ins[15:0];
        bytes_left_d = win_ins[15:0];
      end else begin
        // Drop the oldest header byte and report it
        res_valid_o    = 1'b1;
        res_o.out_byte = win_ins[7:0];
        res_o.kind     = lpfe_pkg::KIND_RESYNC;
        win_d          = {8'd0, win_ins[31:8]};
        fill_d         = 2'd3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= '0;
      fill_q       <= '0;
      in_payload_q <= 1'b0;
      bytes_left_q <= '0;
      frame_len_q  <= '0;
    end else begin
      win_q        <= win_d;
      fill_q       <= fill_d;
      in_payload_q <= in_payload_d;
      bytes_left_q <= bytes_left_d;
      frame_len_q  <= frame_len_d;
    end
  end

  // A frame in progress always has bytes left and an empty window
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (bytes_left_q != 16'd0) && (fill_q == 2'd0))
    else $error("frame active with no bytes left or a partial window");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (bytes_left_q <= frame_len_q))
    else $error("bytes left exceed frame length");

  a_resync_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == lpfe_pkg::KIND_RESYNC) |=> (fill_q == 2'd3))
    else $error("window not refilled to three bytes after resync drop");

endmodule

FILE: dv/length_prefixed_frame_extractor_test.sv
`timescale 1ns / 100ps

module length_prefixed_frame_extractor_test;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned MaxWait     = 11;
  localparam int unsigned ShortFrame  = 40;
  localparam int unsigned MaxPayload  = 65532;
  localparam int unsigned MidFrameLen = 9;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [lpfe_pkg::CfgWidth-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    data_byte_i = 8'h00;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [7:0]                    out_byte_o;
  logic                          kind_o;
  logic                          first_of_frame_o;
  logic                          last_of_frame_o;
  logic [15:0]                   payload_len_o;

  length_prefixed_frame_extractor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .kind_o           (kind_o),
    .first_of_frame_o (first_of_frame_o),
    .last_of_frame_o  (last_of_frame_o),
    .payload_len_o    (payload_len_o)
  );

  // Link bytes waiting to be sent and the deframed transactions they must produce
  logic [7:0]     link_bytes[$];
  lpfe_pkg::res_t deframed_q[$];

  // Deframer state mirrored from the block
  logic [lpfe_pkg::CfgWidth-1:0] max_len = lpfe_pkg::MaxTotalReset;
  logic [31:0]                   hdr_window = '0;
  logic [2:0]                    win_fill = '0;
  logic                          in_frame = 1'b0;
  logic [15:0]                   bytes_left = '0;
  logic [15:0]                   frame_len = '0;

  int unsigned sent_cnt = 0, taken_cnt = 0, queued_cnt = 0;
  int unsigned tx_gap = 0, rx_wait = 0, cycle_cnt = 0, fail_cnt = 0;
  int unsigned frame_cnt = 0, payload_cnt = 0, drop_cnt = 0, cfg_cnt = 0;
  bit          tx_quiet = 1'b0, rx_quiet = 1'b0, no_idle = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the deframer by one accepted link byte
  task automatic deframe_byte(input logic [7:0] b);
    lpfe_pkg::res_t                r;
    logic [lpfe_pkg::CfgWidth-1:0] cap;
    if (in_frame) begin
      r.out_byte       = b;
      r.kind           = lpfe_pkg::KIND_PAYLOAD;
      r.first_of_frame = (bytes_left == frame_len);
      r.last_of_frame  = (bytes_left <= 16'd1);
      r.payload_len    = frame_len;
      deframed_q.insert(deframed_q.size(), r);
      payload_cnt++;
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) in_frame = 1'b0;
    end else begin
      hdr_window[8*win_fill[1:0] +: 8] = b;
      if (win_fill < 3'd4) win_fill++;
      if (win_fill == 3'd4) begin
        cap = (max_len > lpfe_pkg::MaxTotalCap) ? lpfe_pkg::MaxTotalCap : max_len;
        // test the full 32-bit word, no wrap-around
        if (hdr_window != 0 &&
            {1'b0, hdr_window} + 33'(lpfe_pkg::HeaderBytes) <= 33'(cap)) begin
          frame_len  = hdr_window[15:0];
          bytes_left = hdr_window[15:0];
          in_frame   = 1'b1;
          win_fill   = '0;
          hdr_window = '0;
          frame_cnt++;
        end else begin
          // drop the oldest header byte and report it
          r.out_byte       = hdr_window[7:0];
          r.kind           = lpfe_pkg::KIND_RESYNC;
          r.first_of_frame = 1'b0;
          r.last_of_frame  = 1'b0;
          r.payload_len    = '0;
          deframed_q.insert(deframed_q.size(), r);
          hdr_window = hdr_window >> 8;
          win_fill   = 3'd3;
          drop_cnt++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    link_bytes.insert(link_bytes.size(), b);
    queued_cnt++;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
  endtask

  task automatic push_noise(input int unsigned n);
    repeat (n) push_byte(8'($urandom));
  endtask

  task automatic push_frame(input logic [31:0] len);
    push_word(len);
    push_noise(len);
  endtask

  // Write max_total_len while the block is idle
  task automatic write_cap(input logic [lpfe_pkg::CfgWidth-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = v;
    cfg_cnt++;
  endtask

  // Hold until every byte is taken and every transaction has come out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (link_bytes.size() != 0 || in_valid_i || deframed_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed frames, with bad headers and loose bytes mixed in
  task automatic random_traffic(input int unsigned n);
    int unsigned                   target, span, pick;
    logic [lpfe_pkg::CfgWidth-1:0] cap;
    target = queued_cnt + n;
    cap    = (max_len > lpfe_pkg::MaxTotalCap) ? lpfe_pkg::MaxTotalCap : max_len;
    span   = (cap >= 5) ? cap - 4 : 0;
    if (span > ShortFrame) span = ShortFrame;
    while (queued_cnt < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7 && span > 0) begin
        push_frame($urandom_range(1, span));
      end else if (pick < 9) begin
        case ($urandom_range(0, 2))
          0:       push_word(32'd0);
          1:       push_word({15'd0, cap} + $urandom_range(0, 20) - 3);
          default: push_word($urandom);
        endcase
        push_noise($urandom_range(0, 3));
      end else begin
        push_noise($urandom_range(1, 6));
      end
    end
  endtask

  // Drive link bytes, holding each until the block takes it
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || taken_cnt == sent_cnt)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (link_bytes.size() > 0) begin
        data_byte_i <= link_bytes[0];
        link_bytes.delete(0);
        in_valid_i  <= 1'b1;
        sent_cnt++;
        if ($urandom_range(0, 24) == 0) tx_quiet = !tx_quiet;
        tx_gap = (tx_quiet || no_idle) ? 0 : $urandom_range(0, MaxWait);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side for the drawn number of cycles
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_wait > 0 && out_valid_o) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Predict on each accepted byte, compare each accepted result
  always @(posedge clk_i) begin
    lpfe_pkg::res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        taken_cnt++;
        deframe_byte(data_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if ($urandom_range(0, 24) == 0) rx_quiet = !rx_quiet;
        rx_wait = (rx_quiet || no_idle) ? 0 : $urandom_range(0, MaxWait);
        if (deframed_q.size() == 0) begin
          $error("unexpected transaction: out_byte %0h kind %0d", out_byte_o, kind_o);
          fail_cnt++;
        end else begin
          want = deframed_q[0];
          deframed_q.delete(0);
          check_field("out_byte", want.out_byte, out_byte_o);
          check_field("kind", want.kind, kind_o);
          check_field("first_of_frame", want.first_of_frame, first_of_frame_o);
          check_field("last_of_frame", want.last_of_frame, last_of_frame_o);
          check_field("payload_len", want.payload_len, payload_len_o);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $error("timeout after %0d cycles, %0d transactions outstanding",
             cycle_cnt, deframed_q.size());
      $display("length_prefixed_frame_extractor_test failed");
      $finish;
    end
  end

  initial begin
    logic [lpfe_pkg::CfgWidth-1:0] cap;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Reset limit: one-byte frame, two-byte frame, zero length word
    push_word(32'd1);
    push_byte(8'hFF);
    push_word(32'd2);
    push_byte(8'h00);
    push_byte(8'h80);
    push_word(32'd0);
    wait_drained();

    // Smallest useful limit: huge word, length at the limit, one past it
    write_cap(17'd5);
    push_word(32'hFFFF_FFFF);
    push_word(32'd1);
    push_byte(8'hAB);
    push_word(32'd2);
    push_word(32'd1);
    push_byte(8'h5A);
    wait_drained();

    // All-ones limit acts as the cap: a frame sent back to back
    write_cap('1);
    no_idle = 1'b1;
    push_frame(ShortFrame);
    wait_drained();
    no_idle = 1'b0;

    // Just above the cap: one past the longest payload is rejected
    write_cap(17'(lpfe_pkg::MaxTotalCap + 17'd1));
    push_word(MaxPayload + 1);
    push_noise(4);
    wait_drained();

    // Limits below range accept no header
    write_cap('0);
    push_noise(6);
    wait_drained();
    write_cap(17'd4);
    push_noise(6);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       cap = 17'($urandom_range(5, 12));
        1:       cap = 17'($urandom_range(13, 80));
        2:       cap = 17'($urandom_range(81, (1 << lpfe_pkg::CfgWidth) - 1));
        default: cap = lpfe_pkg::MaxTotalCap;
      endcase
      write_cap(cap);
      random_traffic(36);
      if (p == 5) begin
        // leave a frame open so the next limit lands mid-frame
        push_word(MidFrameLen);
        push_noise(MidFrameLen / 2);
      end
      wait_drained();
    end

    write_cap(lpfe_pkg::MaxTotalReset);
    random_traffic(48);
    wait_drained();
    repeat (4) @(posedge clk_i);

    if (deframed_q.size() != 0) begin
      $error("%0d transactions never arrived", deframed_q.size());
      fail_cnt++;
    end
    $display("Sent %0d link bytes across %0d limit settings", queued_cnt, cfg_cnt);
    $display("Predicted %0d frames, %0d payload bytes, %0d resync drops",
             frame_cnt, payload_cnt, drop_cnt);
    if (fail_cnt == 0) begin
      $display("length_prefixed_frame_extractor_test passed");
    end else begin
      $display("length_prefixed_frame_extractor_test failed");
    end
    $finish;
  end

endmodule
